@@ hw/rtl/lpd_pkg.sv @@
// shared types, constants and helpers of the line position pid drive
`default_nettype none

package lpd_pkg;

    // fixed geometry of the sensor bar and the error fixed point format
    localparam int SENSOR_COUNT = 8;
    localparam int FRAC_BITS    = 8;

    // field and register widths
    localparam int SENSOR_W  = 8;
    localparam int GAIN_W    = 16;
    localparam int TARGET_W  = 12;
    localparam int SPEED_W   = 8;
    localparam int LIMIT_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;

    // scan and divide widths: sum of positions up to 36, count up to 8
    localparam int SUM_W      = 6;
    localparam int CNT_W      = 4;
    localparam int STEP_W     = 4;
    localparam int DIVIDEND_W = SUM_W + FRAC_BITS;

    // signed arithmetic widths
    localparam int ERR_W       = 13;
    localparam int DIFF_W      = 14;
    localparam int INTEG_W     = 26;
    localparam int INTEG_SUM_W = 27;
    localparam int HI_W        = 27;
    localparam int MAC_W       = 28;
    localparam int SPD_SUM_W   = 29;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BASE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT   = 3'd5;

    // register reset values
    localparam logic [GAIN_W-1:0]   RST_GAIN_P = 16'd768;
    localparam logic [GAIN_W-1:0]   RST_GAIN_I = 16'd256;
    localparam logic [GAIN_W-1:0]   RST_GAIN_D = 16'd768;
    localparam logic [TARGET_W-1:0] RST_TARGET = 12'd1152;
    localparam logic [SPEED_W-1:0]  RST_BASE   = 8'd130;
    localparam logic [LIMIT_W-1:0]  RST_LIMIT  = 16'd500;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DIV,
        S_ERR,
        S_MUL,
        S_DONE
    } t_state;

    // clamp a signed speed sum to 0..255
    function automatic logic [SPEED_W-1:0] clamp_speed(input logic signed [SPD_SUM_W-1:0] v);
        logic [SPEED_W-1:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > SPD_SUM_W'(255)) begin
            res = '1;
        end else begin
            res = v[SPEED_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/lpd_bit_mac.sv @@
// bit-serial three-term multiply accumulate, one gain bit per cycle
`default_nettype none

module lpd_bit_mac
    import lpd_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [GAIN_W-1:0]         i_gain_p,
    input  wire logic [GAIN_W-1:0]         i_gain_i,
    input  wire logic [GAIN_W-1:0]         i_gain_d,
    input  wire logic signed [ERR_W-1:0]   i_err,
    input  wire logic signed [INTEG_W-1:0] i_integ,
    input  wire logic signed [DIFF_W-1:0]  i_diff,
    output logic                           o_done,
    output logic signed [HI_W-1:0]         o_prod_hi,
    output logic [GAIN_W-1:0]              o_prod_lo
);

    logic                      r_busy;
    logic [STEP_W-1:0]         r_cnt;
    logic [GAIN_W-1:0]         r_kp;
    logic [GAIN_W-1:0]         r_ki;
    logic [GAIN_W-1:0]         r_kd;
    logic signed [ERR_W-1:0]   r_e;
    logic signed [INTEG_W-1:0] r_i;
    logic signed [DIFF_W-1:0]  r_d;
    logic signed [HI_W-1:0]    r_hi;
    logic [GAIN_W-1:0]         r_lo;

    logic signed [MAC_W-1:0] term_p;
    logic signed [MAC_W-1:0] term_i;
    logic signed [MAC_W-1:0] term_d;
    logic signed [MAC_W-1:0] step_sum;

    // partial products selected by the current gain bits
    assign term_p   = r_kp[0] ? MAC_W'(r_e) : '0;
    assign term_i   = r_ki[0] ? MAC_W'(r_i) : '0;
    assign term_d   = r_kd[0] ? MAC_W'(r_d) : '0;
    assign step_sum = MAC_W'(r_hi) + term_p + term_i + term_d;

    assign o_done    = r_busy && (r_cnt == STEP_W'(GAIN_W - 1));
    assign o_prod_hi = r_hi;
    assign o_prod_lo = r_lo;

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (o_done) begin
                r_busy <= 1'b0;
            end
        end
    end

    // operand capture, gain shift and shift-add of the accumulator
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_kp <= i_gain_p;
            r_ki <= i_gain_i;
            r_kd <= i_gain_d;
            r_e  <= i_err;
            r_i  <= i_integ;
            r_d  <= i_diff;
            r_hi <= '0;
            r_lo <= '0;
        end else if (r_busy) begin
            r_kp <= r_kp >> 1;
            r_ki <= r_ki >> 1;
            r_kd <= r_kd >> 1;
            r_hi <= step_sum[MAC_W-1:1];
            r_lo <= {step_sum[0], r_lo[GAIN_W-1:1]};
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/line_position_pid_drive.sv @@
// line position pid drive: sensor scan, position divide, pid law and speed clamp
// an accepted item passes through the scan, position divide, error, multiply and finish states;
// a line-lost item goes from the scan straight to the finish
// one item at a time, paced by the serial scan, divide and multiply
// the next item is accepted once the previous result sits in the output register
// reset: synchronous active low, restores register defaults and clears integral and previous error
`default_nettype none

module line_position_pid_drive
    import lpd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // sensor item in
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  wire logic [SENSOR_W-1:0]   i_s_axis_tdata,   // [7:0] sensor_bits
    // speed item out
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    output logic [2*SPEED_W-1:0]       o_m_axis_tdata,   // [7:0] left_speed, [15:8] right_speed
    output logic                       o_m_axis_tuser,   // [0] line_lost
    // configuration writes
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_W-1:0]      i_cfg_data
);

    // configuration registers
    logic [GAIN_W-1:0]   r_gain_p;
    logic [GAIN_W-1:0]   r_gain_i;
    logic [GAIN_W-1:0]   r_gain_d;
    logic [TARGET_W-1:0] r_target;
    logic [SPEED_W-1:0]  r_base;
    logic [LIMIT_W-1:0]  r_limit;

    // sequencer and datapath registers
    t_state                    r_state, n_state;
    logic [SENSOR_W-1:0]       r_bits, n_bits;
    logic [CNT_W-1:0]          r_idx, n_idx;
    logic [SUM_W-1:0]          r_sum, n_sum;
    logic [CNT_W-1:0]          r_cnt, n_cnt;
    logic [STEP_W-1:0]         r_step, n_step;
    logic [DIVIDEND_W-1:0]     r_num, n_num;
    logic [CNT_W-1:0]          r_rem, n_rem;
    logic                      r_lost, n_lost;
    logic signed [ERR_W-1:0]   r_err, n_err;
    logic signed [ERR_W-1:0]   r_prev, n_prev;
    logic signed [INTEG_W-1:0] r_integ, n_integ;
    logic                      r_out_valid, n_out_valid;
    logic [SPEED_W-1:0]        r_left, n_left;
    logic [SPEED_W-1:0]        r_right, n_right;
    logic                      r_out_lost, n_out_lost;

    logic                        mac_start;
    logic                        mac_done;
    logic signed [HI_W-1:0]      mac_hi;
    logic [GAIN_W-1:0]           mac_lo;

    logic [CNT_W:0]                rem2;
    logic                          div_ge;
    logic signed [ERR_W-1:0]       err_calc;
    logic signed [DIFF_W-1:0]      diff_calc;
    logic signed [MAC_W-1:0]       ctrl;
    logic signed [SPD_SUM_W-1:0]   base_s;
    logic signed [SPD_SUM_W-1:0]   spd_r;
    logic signed [SPD_SUM_W-1:0]   spd_l;
    logic signed [INTEG_SUM_W-1:0] integ_sum;
    logic signed [INTEG_SUM_W-1:0] lim_s;

    // handshake outputs
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_right, r_left};
    assign o_m_axis_tuser  = r_out_lost;

    // restoring divide step: remainder with next dividend bit
    assign rem2   = {r_rem, r_num[DIVIDEND_W-1]};
    assign div_ge = (rem2 >= {1'b0, r_cnt});

    // error and its change against the last tracked sample
    assign err_calc  = $signed({1'b0, r_target}) - $signed({1'b0, r_num[TARGET_W-1:0]});
    assign diff_calc = DIFF_W'(err_calc) - DIFF_W'(r_prev);

    // control truncated toward zero: round up the floor when negative with a remainder
    assign ctrl   = MAC_W'(mac_hi) + $signed({{(MAC_W-1){1'b0}},
                                              (mac_hi[HI_W-1] && (mac_lo != '0))});
    assign base_s = $signed({{(SPD_SUM_W-SPEED_W){1'b0}}, r_base});
    assign spd_r  = base_s + SPD_SUM_W'(ctrl);
    assign spd_l  = base_s - SPD_SUM_W'(ctrl);

    // integral update against the symmetric limit
    assign integ_sum = INTEG_SUM_W'(r_integ) + INTEG_SUM_W'(r_err);
    assign lim_s     = INTEG_SUM_W'($signed({1'b0, r_limit, {FRAC_BITS{1'b0}}}));

    lpd_bit_mac u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mac_start),
        .i_gain_p  (r_gain_p),
        .i_gain_i  (r_gain_i),
        .i_gain_d  (r_gain_d),
        .i_err     (err_calc),
        .i_integ   (r_integ),
        .i_diff    (diff_calc),
        .o_done    (mac_done),
        .o_prod_hi (mac_hi),
        .o_prod_lo (mac_lo)
    );

    // next state and datapath
    always_comb begin
        n_state     = r_state;
        n_bits      = r_bits;
        n_idx       = r_idx;
        n_sum       = r_sum;
        n_cnt       = r_cnt;
        n_step      = r_step;
        n_num       = r_num;
        n_rem       = r_rem;
        n_lost      = r_lost;
        n_err       = r_err;
        n_prev      = r_prev;
        n_integ     = r_integ;
        n_left      = r_left;
        n_right     = r_right;
        n_out_lost  = r_out_lost;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        mac_start   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_bits  = i_s_axis_tdata;
                    n_idx   = CNT_W'(1);
                    n_sum   = '0;
                    n_cnt   = '0;
                    n_step  = '0;
                    n_state = S_SCAN;
                end
            end
            // one sensor bit per cycle
            S_SCAN: begin
                n_bits = r_bits >> 1;
                n_idx  = r_idx + 1'b1;
                n_step = r_step + 1'b1;
                if (r_bits[0]) begin
                    n_sum = r_sum + SUM_W'(r_idx);
                    n_cnt = r_cnt + 1'b1;
                end
                if (r_step == STEP_W'(SENSOR_COUNT - 1)) begin
                    n_step  = '0;
                    n_rem   = '0;
                    n_num   = {n_sum, {FRAC_BITS{1'b0}}};
                    n_lost  = (n_cnt == '0);
                    n_state = (n_cnt == '0) ? S_DONE : S_DIV;
                end
            end
            // one quotient bit per cycle
            S_DIV: begin
                n_rem  = div_ge ? CNT_W'(rem2 - {1'b0, r_cnt}) : CNT_W'(rem2);
                n_num  = {r_num[DIVIDEND_W-2:0], div_ge};
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(DIVIDEND_W - 1)) begin
                    n_step  = '0;
                    n_state = S_ERR;
                end
            end
            S_ERR: begin
                n_err     = err_calc;
                mac_start = 1'b1;
                n_state   = S_MUL;
            end
            S_MUL: begin
                if (mac_done) begin
                    n_state = S_DONE;
                end
            end
            // finish when the output register is free
            S_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    if (r_lost) begin
                        n_left     = '0;
                        n_right    = '0;
                        n_out_lost = 1'b1;
                        n_integ    = '0;
                    end else begin
                        n_left     = clamp_speed(spd_l);
                        n_right    = clamp_speed(spd_r);
                        n_out_lost = 1'b0;
                        n_prev     = r_err;
                        if (integ_sum > lim_s) begin
                            n_integ = INTEG_W'(lim_s);
                        end else if (integ_sum < -lim_s) begin
                            n_integ = INTEG_W'(-lim_s);
                        end else begin
                            n_integ = INTEG_W'(integ_sum);
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state, pid state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_integ     <= '0;
            r_prev      <= '0;
            r_gain_p    <= RST_GAIN_P;
            r_gain_i    <= RST_GAIN_I;
            r_gain_d    <= RST_GAIN_D;
            r_target    <= RST_TARGET;
            r_base      <= RST_BASE;
            r_limit     <= RST_LIMIT;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_integ     <= n_integ;
            r_prev      <= n_prev;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_GAIN_P: r_gain_p <= i_cfg_data[GAIN_W-1:0];
                    REG_GAIN_I: r_gain_i <= i_cfg_data[GAIN_W-1:0];
                    REG_GAIN_D: r_gain_d <= i_cfg_data[GAIN_W-1:0];
                    REG_TARGET: r_target <= i_cfg_data[TARGET_W-1:0];
                    REG_BASE:   r_base   <= i_cfg_data[SPEED_W-1:0];
                    REG_LIMIT:  r_limit  <= i_cfg_data[LIMIT_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_bits     <= n_bits;
        r_idx      <= n_idx;
        r_sum      <= n_sum;
        r_cnt      <= n_cnt;
        r_step     <= n_step;
        r_num      <= n_num;
        r_rem      <= n_rem;
        r_lost     <= n_lost;
        r_err      <= n_err;
        r_left     <= n_left;
        r_right    <= n_right;
        r_out_lost <= n_out_lost;
    end

endmodule

`default_nettype wire

@@ test/line_position_pid_drive_test.sv @@
`timescale 1ns / 1ps
// self-checking testbench of the line position pid drive

module line_position_pid_drive_test;
    import lpd_pkg::*;

    // indexes past the last register, writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [SPEED_W-1:0] left;
        logic [SPEED_W-1:0] right;
        logic               lost;
    } drive_t;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_RANDOM,
        READY_SPARSE
    } ready_mode_t;

    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [SENSOR_W-1:0]  i_s_axis_tdata  = '0;   // [7:0] sensor_bits
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [2*SPEED_W-1:0] o_m_axis_tdata;         // [7:0] left_speed, [15:8] right_speed
    logic                 o_m_axis_tuser;         // [0] line_lost
    logic                 i_cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index     = '0;
    logic [CFG_W-1:0]     i_cfg_data      = '0;

    // controller settings and loop state as the block should hold them
    longint gain_p, gain_i, gain_d, target_pos, base_spd, integ_limit;
    longint integ_sum, last_error;

    logic [SENSOR_W-1:0] pending_samples[$];
    drive_t              expected_drives[$];
    int                  queued_count   = 0;
    int                  accepted_count = 0;
    int                  mismatch_count = 0;

    // sender burst and gap bookkeeping
    int burst_left = 1;
    int gap_left   = 0;

    // receiver stall pattern
    ready_mode_t ready_mode = READY_ALWAYS;
    int          mode_left  = 0;
    int          ready_tick = 0;

    line_position_pid_drive u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("[line_position_pid_drive] ERROR");
        $finish;
    end

    function automatic logic [SPEED_W-1:0] speed_of(longint v);
        if (v < 0) begin
            return '0;
        end
        if (v > 255) begin
            return '1;
        end
        return v[SPEED_W-1:0];
    endfunction

    // pid law on one sensor sample, advances integral and last error
    function automatic drive_t predict_drive(logic [SENSOR_W-1:0] bits);
        drive_t d;
        longint pos_sum, hits, position, err, acc, mag, control, clip;
        pos_sum = 0;
        hits    = 0;
        for (int k = 0; k < SENSOR_COUNT; k++) begin
            if (bits[k]) begin
                pos_sum += k + 1;
                hits++;
            end
        end
        if (hits == 0) begin
            // line lost: motors stop, integral cleared, last error kept
            integ_sum = 0;
            d.left    = '0;
            d.right   = '0;
            d.lost    = 1'b1;
        end else begin
            position = (pos_sum << FRAC_BITS) / hits;
            err      = target_pos - position;
            acc      = gain_p * err + gain_i * integ_sum + gain_d * (err - last_error);
            mag      = (acc < 0) ? -acc : acc;
            mag      = mag >> (8 + FRAC_BITS);
            control  = (acc < 0) ? -mag : mag;
            clip     = integ_limit << FRAC_BITS;
            integ_sum += err;
            if (integ_sum > clip) begin
                integ_sum = clip;
            end
            if (integ_sum < -clip) begin
                integ_sum = -clip;
            end
            last_error = err;
            d.left  = speed_of(base_spd - control);
            d.right = speed_of(base_spd + control);
            d.lost  = 1'b0;
        end
        return d;
    endfunction

    // driver: feeds pending samples in bursts, predicts each accepted item
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                expected_drives.push_back(predict_drive(i_s_axis_tdata));
                accepted_count++;
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_s_axis_tvalid <= 1'b0;
                end else if (pending_samples.size() > 0) begin
                    i_s_axis_tdata  <= pending_samples.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
                    end
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each accepted result against the oldest prediction
    always @(posedge i_clk) begin : monitor
        drive_t want;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_drives.size() == 0) begin
                    $display("%0t unexpected result: expected none, actual %h/%b", $time,
                             o_m_axis_tdata, o_m_axis_tuser);
                    mismatch_count++;
                end else begin
                    want = expected_drives.pop_front();
                    if (o_m_axis_tdata[SPEED_W-1:0] !== want.left) begin
                        $display("%0t left_speed expected %0d actual %0d", $time, want.left,
                                 o_m_axis_tdata[SPEED_W-1:0]);
                        mismatch_count++;
                    end
                    if (o_m_axis_tdata[2*SPEED_W-1:SPEED_W] !== want.right) begin
                        $display("%0t right_speed expected %0d actual %0d", $time, want.right,
                                 o_m_axis_tdata[2*SPEED_W-1:SPEED_W]);
                        mismatch_count++;
                    end
                    if (o_m_axis_tuser !== want.lost) begin
                        $display("%0t line_lost expected %0d actual %0d", $time, want.lost,
                                 o_m_axis_tuser);
                        mismatch_count++;
                    end
                end
            end
            // stall pattern: always ready, coin flips, or one cycle in eight
            if (mode_left == 0) begin
                ready_mode = ready_mode_t'($urandom_range(0, 2));
                mode_left  = $urandom_range(20, 300);
            end else begin
                mode_left--;
            end
            ready_tick++;
            case (ready_mode)
                READY_ALWAYS: i_m_axis_tready <= 1'b1;
                READY_RANDOM: i_m_axis_tready <= ($urandom_range(0, 1) == 1);
                default:      i_m_axis_tready <= (ready_tick % 8 == 0);
            endcase
        end
    end

    task automatic queue_sample(logic [SENSOR_W-1:0] bits);
        pending_samples.push_back(bits);
        queued_count++;
    endtask

    // hold until every queued item is accepted and its result checked
    task automatic wait_idle();
        do begin
            @(posedge i_clk);
        end while (accepted_count != queued_count || expected_drives.size() != 0);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            REG_GAIN_P: gain_p      = value;
            REG_GAIN_I: gain_i      = value;
            REG_GAIN_D: gain_d      = value;
            REG_TARGET: target_pos  = value[TARGET_W-1:0];
            REG_BASE:   base_spd    = value[SPEED_W-1:0];
            REG_LIMIT:  integ_limit = value;
            default: ;
        endcase
    endtask

    function automatic logic [CFG_W-1:0] random_gain();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return '0;
        end
        if (r == 1) begin
            return '1;
        end
        if (r < 7) begin
            return CFG_W'($urandom_range(0, 1024));
        end
        return CFG_W'($urandom);
    endfunction

    // new random setting for every register, extremes included
    task automatic pick_drive_setting();
        int                   r;
        logic [TARGET_W-1:0]  tgt;
        logic [SPEED_W-1:0]   bs;
        logic [LIMIT_W-1:0]   lim;
        write_reg(REG_GAIN_P, random_gain());
        write_reg(REG_GAIN_I, random_gain());
        write_reg(REG_GAIN_D, random_gain());
        r = $urandom_range(0, 5);
        if (r == 0) begin
            tgt = 12'd256;
        end else if (r == 1) begin
            tgt = 12'd2048;
        end else if (r == 2) begin
            tgt = TARGET_W'($urandom);
        end else begin
            tgt = TARGET_W'($urandom_range(256, 2048));
        end
        write_reg(REG_TARGET, {4'($urandom), tgt});
        r = $urandom_range(0, 5);
        bs = (r == 0) ? 8'd0 : (r == 1) ? 8'd255 : 8'($urandom);
        write_reg(REG_BASE, {8'($urandom), bs});
        r = $urandom_range(0, 9);
        if (r == 0) begin
            lim = '0;
        end else if (r == 1) begin
            lim = '1;
        end else if (r < 6) begin
            lim = LIMIT_W'($urandom_range(1, 16));
        end else begin
            lim = LIMIT_W'($urandom_range(0, 1000));
        end
        write_reg(REG_LIMIT, lim);
        if ($urandom_range(0, 2) == 0) begin
            write_reg(($urandom_range(0, 1) == 0) ? REG_SPARE_LO : REG_SPARE_HI,
                      CFG_W'($urandom));
        end
    endtask

    // stimulus: directed corners, then random phases of samples
    initial begin
        logic [SENSOR_W-1:0] sample;
        int                  center;
        int                  width;
        int                  kind;
        gain_p      = RST_GAIN_P;
        gain_i      = RST_GAIN_I;
        gain_d      = RST_GAIN_D;
        target_pos  = RST_TARGET;
        base_spd    = RST_BASE;
        integ_limit = RST_LIMIT;
        integ_sum   = 0;
        last_error  = 0;
        center      = 3;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: edges of the bar, full bar, lost line and recovery
        queue_sample(8'h00);
        queue_sample(8'h01);
        queue_sample(8'h80);
        queue_sample(8'hFF);
        queue_sample(8'h18);
        queue_sample(8'h81);
        queue_sample(8'h03);
        queue_sample(8'hC0);
        queue_sample(8'h55);
        queue_sample(8'hAA);
        queue_sample(8'h00);
        queue_sample(8'h01);
        queue_sample(8'h01);
        wait_idle();

        // full gains with integral limit zero and the largest target
        write_reg(REG_GAIN_P, '1);
        write_reg(REG_GAIN_I, '1);
        write_reg(REG_GAIN_D, '1);
        write_reg(REG_LIMIT, '0);
        write_reg(REG_TARGET, '1);
        queue_sample(8'h01);
        queue_sample(8'h80);
        queue_sample(8'h01);
        queue_sample(8'h00);
        wait_idle();

        // huge negative control: target zero, widest limit, top base speed
        write_reg(REG_LIMIT, '1);
        write_reg(REG_TARGET, 16'hF000);
        write_reg(REG_BASE, 16'hFFFF);
        queue_sample(8'h80);
        queue_sample(8'h80);
        queue_sample(8'h80);
        wait_idle();

        // zero base speed, plain proportional law, writes to spare indexes
        write_reg(REG_GAIN_P, 16'd256);
        write_reg(REG_GAIN_I, '0);
        write_reg(REG_GAIN_D, '0);
        write_reg(REG_BASE, 16'hFF00);
        write_reg(REG_SPARE_LO, '1);
        write_reg(REG_SPARE_HI, '0);
        queue_sample(8'h01);
        queue_sample(8'h80);
        wait_idle();

        for (int p = 0; p < 10; p++) begin
            pick_drive_setting();
            for (int n = 0; n < 75; n++) begin
                kind = $urandom_range(0, 19);
                if (kind < 11) begin
                    // a line under the bar: a run of one to three sensors drifting
                    center += int'($urandom_range(0, 2)) - 1;
                    if (center < 0) begin
                        center = 0;
                    end
                    if (center > SENSOR_COUNT - 1) begin
                        center = SENSOR_COUNT - 1;
                    end
                    width  = $urandom_range(1, 3);
                    sample = SENSOR_W'(((1 << width) - 1) << center);
                end else if (kind < 17) begin
                    sample = SENSOR_W'($urandom);
                end else begin
                    sample = '0;
                end
                queue_sample(sample);
            end
            wait_idle();
        end

        repeat (50) @(posedge i_clk);
        if (expected_drives.size() != 0) begin
            $display("%0t %0d results never arrived", $time, expected_drives.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("[line_position_pid_drive] OK");
        end else begin
            $display("[line_position_pid_drive] ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/lpd_pkg.sv
hw/rtl/lpd_bit_mac.sv
hw/rtl/line_position_pid_drive.sv
test/line_position_pid_drive_test.sv
